### hdl/wpc_pkg.sv
// wpc_pkg: shared types and constants for the Wilson prime checker.
// Used by wpc_ctrl, wpc_datapath and wilson_prime_checker_top.
`default_nettype none

package wpc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // Datapath operations, one issued per cycle by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // latch candidate, first divisor, clear found flag
    OP_SQ_D,       // square <= d * d
    OP_DIV_INIT,   // modulus <= d, bit shifter <= n, accumulator <= 0
    OP_SHIFT,      // accumulator <= (2 * acc + bit) mod m
    OP_SET_FOUND,  // proper divisor seen
    OP_NEXT_D,     // d <= d + 1
    OP_SQ_N,       // square <= n * n
    OP_FACT_INIT,  // modulus <= n * n, residue <= 1, d <= 2
    OP_MUL_INIT,   // bit shifter <= d, accumulator <= 0
    OP_ADD,        // accumulator <= (acc + residue) mod m when the bit is set
    OP_TAKE        // residue <= accumulator, d <= d + 1
  } dp_op_e;

  typedef struct packed {
    logic sq_le_n;   // d * d <= n
    logic acc_zero;  // remainder is zero
    logic d_lt_n;    // factor index below n
    logic is_prime;  // n >= 2 and no divisor seen
  } dp_status_t;

endpackage : wpc_pkg

`default_nettype wire

### hdl/wilson_prime_checker_top.sv
// wilson_prime_checker_top: primality and Wilson prime test, one candidate
// per request. Instantiates wpc_ctrl and wpc_datapath; depends on wpc_pkg.
// Usage:
//   Drive candidate_i and raise start while busy is low; the request is
//   taken at that clock edge and busy rises on the next cycle.
//   When the test ends, done_o is high for exactly one cycle with
//   tested_value_o, is_prime_o and is_wilson_o valid; the receiver cannot
//   hold the result off. busy is already low in that cycle, so the next
//   request may be taken at the same edge.
// Sequence: trial division and the factorial of a prime both go through one
// bit-serial modular reduction unit. Each trial divisor d (while d*d <= n)
// is squared and compared with n; n is then shifted in bit by bit and the
// remainder is checked. Each factorial step of a prime tests d < n, then
// runs a shift and conditional add per bit of the factor and takes the
// product as the new residue. A composite n stops at its smallest factor;
// a prime n tries every divisor up to floor(sqrt(n)), then runs the
// factorial steps for d = 2 .. n-1.
// One request is in flight at a time. Reset (rst_ni low, asynchronous)
// returns the sequencer to idle and clears done_o; result ports hold no
// meaning until the first done_o strobe.
`default_nettype none

module wilson_prime_checker_top
  import wpc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] candidate_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      tested_value_o,
  output logic                        is_prime_o,
  output logic                        is_wilson_o
);

  dp_op_e     op;
  dp_status_t status;

  wpc_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .done_o  (done_o),
    .status_i(status),
    .op_o    (op)
  );

  wpc_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .candidate_i   (candidate_i),
    .status_o      (status),
    .tested_value_o(tested_value_o),
    .is_prime_o    (is_prime_o),
    .is_wilson_o   (is_wilson_o)
  );

endmodule : wilson_prime_checker_top

`default_nettype wire

### hdl/wpc_datapath.sv
// wpc_datapath: candidate, divisor and residue registers, squarer and a
// bit-serial modular reduction unit shared by trial division and mul-mod.
// Depends on wpc_pkg.
`default_nettype none

module wpc_datapath
  import wpc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dp_op_e                 op_i,
  input  wire logic [VALUE_WIDTH-1:0] candidate_i,
  output dp_status_t                  status_o,
  output logic [VALUE_WIDTH-1:0]      tested_value_o,
  output logic                        is_prime_o,
  output logic                        is_wilson_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned DW = 2 * VALUE_WIDTH;

  logic [W-1:0]  n_q, d_q, sh_q;
  logic [DW-1:0] sq_q, m_q, r_q, acc_q;
  logic          mul_mode_q, found_q;

  logic [W-1:0]  sq_op;
  logic [DW-1:0] sq_prod;
  logic          bit_in;
  logic [DW:0]   sh_sum, sh_red, add_sum, add_red;
  logic          prime;

  assign sq_op   = (op_i == OP_SQ_N) ? n_q : d_q;
  assign sq_prod = DW'(sq_op) * DW'(sq_op);

  // restoring step: 2*acc + bit stays below 2*m, one subtract brings it under m
  assign bit_in  = mul_mode_q ? 1'b0 : sh_q[W-1];
  assign sh_sum  = {acc_q, bit_in};
  assign sh_red  = (sh_sum >= {1'b0, m_q}) ? sh_sum - {1'b0, m_q} : sh_sum;
  assign add_sum = {1'b0, acc_q} + {1'b0, r_q};
  assign add_red = (add_sum >= {1'b0, m_q}) ? add_sum - {1'b0, m_q} : add_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      mul_mode_q <= 1'b0;
    end else begin
      unique case (op_i)
        OP_LOAD: begin
          found_q <= 1'b0;
        end
        OP_SET_FOUND: begin
          found_q <= 1'b1;
        end
        OP_DIV_INIT: begin
          mul_mode_q <= 1'b0;
        end
        OP_MUL_INIT: begin
          mul_mode_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i) inside
      OP_LOAD: begin
        n_q <= candidate_i;
        d_q <= W'(2);
      end
      OP_SQ_D, OP_SQ_N: begin
        sq_q <= sq_prod;
      end
      OP_DIV_INIT: begin
        m_q   <= {{W{1'b0}}, d_q};
        sh_q  <= n_q;
        acc_q <= '0;
      end
      OP_SHIFT: begin
        acc_q <= sh_red[DW-1:0];
        if (!mul_mode_q) begin
          sh_q <= {sh_q[W-2:0], 1'b0};
        end
      end
      OP_NEXT_D: begin
        d_q <= d_q + W'(1);
      end
      OP_FACT_INIT: begin
        m_q <= sq_q;
        r_q <= DW'(1);
        d_q <= W'(2);
      end
      OP_MUL_INIT: begin
        sh_q  <= d_q;
        acc_q <= '0;
      end
      OP_ADD: begin
        if (sh_q[W-1]) begin
          acc_q <= add_red[DW-1:0];
        end
        sh_q <= {sh_q[W-2:0], 1'b0};
      end
      OP_TAKE: begin
        r_q <= acc_q;
        d_q <= d_q + W'(1);
      end
      default: begin
      end
    endcase
  end

  assign prime = (n_q >= W'(2)) && !found_q;

  assign status_o.sq_le_n  = (sq_q <= {{W{1'b0}}, n_q});
  assign status_o.acc_zero = (acc_q == '0);
  assign status_o.d_lt_n   = (d_q < n_q);
  assign status_o.is_prime = prime;

  assign tested_value_o = n_q;
  assign is_prime_o     = prime;
  assign is_wilson_o    = prime && (r_q == (m_q - DW'(1)));

endmodule : wpc_datapath

`default_nettype wire

### hdl/wpc_ctrl.sv
// wpc_ctrl: sequencer for trial division and the modular factorial loop.
// Drives wpc_datapath through dp_op_e; depends on wpc_pkg.
`default_nettype none

module wpc_ctrl
  import wpc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  output logic            done_o,
  input  wire dp_status_t status_i,
  output dp_op_e          op_o
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_D,
    S_CHK_D,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_CHK,
    S_SQ_N,
    S_FACT_INIT,
    S_MUL_TEST,
    S_MUL_INIT,
    S_MUL_SHIFT,
    S_MUL_ADD,
    S_MUL_END
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_o    = OP_LOAD;
          state_d = S_SQ_D;
        end
      end
      S_SQ_D: begin
        op_o    = OP_SQ_D;
        state_d = S_CHK_D;
      end
      S_CHK_D: begin
        if (status_i.sq_le_n) begin
          state_d = S_DIV_INIT;
        end else if (status_i.is_prime) begin
          state_d = S_SQ_N;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV_INIT: begin
        op_o    = OP_DIV_INIT;
        cnt_d   = CW'(VALUE_WIDTH - 1);
        state_d = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        op_o  = OP_SHIFT;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = S_DIV_CHK;
        end
      end
      S_DIV_CHK: begin
        if (status_i.acc_zero) begin
          op_o    = OP_SET_FOUND;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_NEXT_D;
          state_d = S_SQ_D;
        end
      end
      S_SQ_N: begin
        op_o    = OP_SQ_N;
        state_d = S_FACT_INIT;
      end
      S_FACT_INIT: begin
        op_o    = OP_FACT_INIT;
        state_d = S_MUL_TEST;
      end
      S_MUL_TEST: begin
        state_d = status_i.d_lt_n ? S_MUL_INIT : S_IDLE;
      end
      S_MUL_INIT: begin
        op_o    = OP_MUL_INIT;
        cnt_d   = CW'(VALUE_WIDTH - 1);
        state_d = S_MUL_SHIFT;
      end
      S_MUL_SHIFT: begin
        op_o    = OP_SHIFT;
        state_d = S_MUL_ADD;
      end
      S_MUL_ADD: begin
        op_o    = OP_ADD;
        cnt_d   = cnt_q - CW'(1);
        state_d = (cnt_q == '0) ? S_MUL_END : S_MUL_SHIFT;
      end
      S_MUL_END: begin
        op_o    = OP_TAKE;
        state_d = S_MUL_TEST;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // strobe in the first idle cycle, once the last datapath update has landed
  assign done_d = (state_q != S_IDLE) && (state_d == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule : wpc_ctrl

`default_nettype wire

### tb/tb_wilson_prime_checker_top.sv
// tb_wilson_prime_checker_top: self-checking testbench for the primality and
// Wilson prime test. Depends on wpc_pkg and wilson_prime_checker_top.
// Predicts each verdict by trial division and a modular factorial.
`timescale 1ns / 1ps

module tb_wilson_prime_checker_top
  import wpc_pkg::*;
();

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam int unsigned MAX_DIVISOR = 258;  // covers sqrt of the widest candidate

  typedef struct packed {
    logic [VW-1:0] tested_value;
    logic          is_prime;
    logic          is_wilson;
  } wilson_verdict_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic [VW-1:0] candidate_i = '0;
  logic          busy;
  logic          done_o;
  logic [VW-1:0] tested_value_o;
  logic          is_prime_o;
  logic          is_wilson_o;

  wilson_verdict_t pending_verdicts[$];
  wilson_verdict_t oldest_verdict;
  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_budget = 0;

  wilson_prime_checker_top #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .candidate_i   (candidate_i),
    .done_o        (done_o),
    .tested_value_o(tested_value_o),
    .is_prime_o    (is_prime_o),
    .is_wilson_o   (is_wilson_o)
  );

  always #5 clk_i = ~clk_i;

  // Verdict for one candidate: trial division up to sqrt(n), then (n-1)!
  // reduced modulo n*n for primes.
  function automatic wilson_verdict_t predict_verdict(input logic [VW-1:0] n);
    wilson_verdict_t verdict;
    longint unsigned value;
    longint unsigned d;
    longint unsigned square;
    longint unsigned residue;
    logic            found;
    value = n;
    found = 1'b0;
    for (d = 2; !found && d * d <= value; d++) begin
      if (value % d == 0) found = 1'b1;
    end
    verdict.tested_value = n;
    verdict.is_prime     = (value >= 2) && !found;
    verdict.is_wilson    = 1'b0;
    if (verdict.is_prime) begin
      square  = value * value;
      residue = 1 % square;
      for (d = 2; d < value; d++) residue = (residue * d) % square;
      verdict.is_wilson = (residue == square - 1);
    end
    return verdict;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(2);
    if (roll < 95) return $urandom_range(12, 3);
    return $urandom_range(300, 50);
  endfunction

  // Holds start high over back-to-back requests; a gap lowers it first, and
  // the caller lowers it at the end through drain_results.
  task automatic send_candidate(input logic [VW-1:0] n, input int unsigned gap);
    wilson_verdict_t verdict;
    verdict = predict_verdict(n);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    candidate_i <= n;
    cycle_budget += gap + 64 + MAX_DIVISOR * (VW + 4);
    if (verdict.is_prime) cycle_budget += longint'(n) * (2 * VW + 3);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_verdicts.push_back(verdict);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // Zero, one, two, three and the smallest composite.
  task automatic test_special_values();
    send_candidate(16'd0, 0);
    send_candidate(16'd1, pick_gap());
    send_candidate(16'd2, pick_gap());
    send_candidate(16'd3, pick_gap());
    send_candidate(16'd4, 0);
    drain_results();
  endtask

  // The Wilson primes in range and some primes that are not.
  task automatic test_wilson_primes();
    send_candidate(16'd5, 0);
    send_candidate(16'd7, 0);
    send_candidate(16'd13, pick_gap());
    send_candidate(16'd11, pick_gap());
    send_candidate(16'd563, 0);
    send_candidate(16'd17, pick_gap());
    send_candidate(16'd29, 0);
    drain_results();
  endtask

  // Top of the range, alternating bit patterns, a semiprime of two large
  // factors and a mid-size prime.
  task automatic test_field_extremes();
    send_candidate(16'hFFFF, 0);
    send_candidate(16'h8000, pick_gap());
    send_candidate(16'hFFFE, 0);
    send_candidate(16'hAAAA, pick_gap());
    send_candidate(16'h5555, 0);
    send_candidate(16'd64507, pick_gap());
    send_candidate(16'd4093, 0);
    drain_results();
  endtask

  task automatic test_back_to_back();
    repeat (12) send_candidate(VW'($urandom_range(200, 2)), 0);
    drain_results();
  endtask

  task automatic test_random_mix();
    logic [VW-1:0]   n;
    logic [VW-1:0]   p;
    logic [VW-1:0]   q;
    wilson_verdict_t verdict;
    int unsigned     roll;
    repeat (76) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        n = VW'($urandom_range(1023, 2));
      end else if (roll < 70) begin
        // full range; large primes are too slow, so step down to an even value
        n = VW'($urandom_range(65535, 2));
        verdict = predict_verdict(n);
        if (verdict.is_prime && n > 1023) n = n - 1'b1;
      end else if (roll < 85) begin
        p = VW'($urandom_range(250, 101) | 1);
        verdict = predict_verdict(p);
        while (!verdict.is_prime) begin
          p = p + 2'd2;
          verdict = predict_verdict(p);
        end
        q = VW'($urandom_range(250, 101) | 1);
        verdict = predict_verdict(q);
        while (!verdict.is_prime) begin
          q = q + 2'd2;
          verdict = predict_verdict(q);
        end
        n = VW'(p * q);
      end else begin
        roll = $urandom_range(5);
        if (roll == 0) n = 16'd5;
        else if (roll == 1) n = 16'd13;
        else if (roll == 2) n = 16'd563;
        else begin
          n = VW'($urandom_range(600, 2));
          verdict = predict_verdict(n);
          while (!verdict.is_prime) begin
            n = n + 1'b1;
            verdict = predict_verdict(n);
          end
        end
      end
      send_candidate(n, pick_gap());
    end
    drain_results();
  endtask

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result for candidate %0d", $time, tested_value_o);
        error_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (tested_value_o !== oldest_verdict.tested_value) begin
          $display("%0t: tested_value expected %0d actual %0d", $time,
                   oldest_verdict.tested_value, tested_value_o);
          error_count++;
        end
        if (is_prime_o !== oldest_verdict.is_prime) begin
          $display("%0t: is_prime for %0d expected %0b actual %0b", $time,
                   oldest_verdict.tested_value, oldest_verdict.is_prime, is_prime_o);
          error_count++;
        end
        if (is_wilson_o !== oldest_verdict.is_wilson) begin
          $display("%0t: is_wilson for %0d expected %0b actual %0b", $time,
                   oldest_verdict.tested_value, oldest_verdict.is_wilson, is_wilson_o);
          error_count++;
        end
      end
    end
  end

  // Limit grows with the worst-case work of every request sent so far.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 100000) begin
      $display("%0t: timeout with %0d requests outstanding", $time,
               pending_verdicts.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_wilson_primes();
    test_field_extremes();
    test_back_to_back();
    test_random_mix();
    repeat (2 * VW + 16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
